// File: hdl/keyboard_report_key_events_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard report event decoder
// Shared forms for concurrent checks, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_REPORT_KEY_EVENTS_ASSERT_SVH
`define KEYBOARD_REPORT_KEY_EVENTS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KRE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define KRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/kre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kre_pkg
// Types, constants and the character table of the keyboard report decoder.
// ----------------------------------------------------------------------------
package kre_pkg;

  localparam int unsigned CodeW     = 8;
  localparam int unsigned LenW      = 7;
  localparam logic [7:0]  FirstCode = 8'd4;
  localparam logic [7:0]  LastCode  = 8'd56;
  localparam logic [7:0]  EnterCode = 8'd40;
  localparam logic [6:0]  MinReport = 7'd8;
  localparam logic [7:0]  EnterRst  = 8'd13;
  localparam int unsigned LShiftBit = 1;
  localparam int unsigned RShiftBit = 5;

  // what one lane found for its slot
  typedef struct packed {
    logic       rel;
    logic       prs;
    logic [7:0] old_code;
    logic [7:0] new_code;
    logic       char_valid;
    logic [7:0] char_code;
  } lane_evt_t;

  // one event as it leaves the block
  typedef struct packed {
    logic [7:0] usage_code;
    logic       pressed;
    logic [7:0] modifier;
    logic       char_valid;
    logic [7:0] char_code;
    logic       last_event;
  } evt_t;

  // character for codes 4..56 except enter; 0 where no character
  function automatic logic [7:0] kre_char(input logic [7:0] code, input logic shift);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (code)
      8'd30: ch = shift ? 8'h21 : 8'h31;
      8'd31: ch = shift ? 8'h40 : 8'h32;
      8'd32: ch = shift ? 8'h23 : 8'h33;
      8'd33: ch = shift ? 8'h24 : 8'h34;
      8'd34: ch = shift ? 8'h25 : 8'h35;
      8'd35: ch = shift ? 8'h5E : 8'h36;
      8'd36: ch = shift ? 8'h26 : 8'h37;
      8'd37: ch = shift ? 8'h2A : 8'h38;
      8'd38: ch = shift ? 8'h28 : 8'h39;
      8'd39: ch = shift ? 8'h29 : 8'h30;
      8'd42: ch = shift ? 8'h00 : 8'h08;
      8'd44: ch = 8'h20;
      8'd45: ch = shift ? 8'h5F : 8'h2D;
      8'd46: ch = shift ? 8'h2B : 8'h3D;
      8'd47: ch = shift ? 8'h7B : 8'h5B;
      8'd48: ch = shift ? 8'h7D : 8'h5D;
      8'd49: ch = shift ? 8'h7C : 8'h5C;
      8'd50: ch = shift ? 8'h7C : 8'h5C;
      8'd51: ch = shift ? 8'h3A : 8'h3B;
      8'd52: ch = shift ? 8'h22 : 8'h27;
      8'd53: ch = shift ? 8'h7E : 8'h60;
      8'd54: ch = shift ? 8'h3C : 8'h2C;
      8'd55: ch = shift ? 8'h3E : 8'h2E;
      8'd56: ch = shift ? 8'h3F : 8'h2F;
      default: begin
        // letters a..z; everything else has no character
        if (code >= FirstCode && code <= 8'd29) begin
          ch = (shift ? 8'h41 : 8'h61) + (code - FirstCode);
        end
      end
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/kre_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kre_lane
// One key slot: release and press detection plus character lookup.
// ----------------------------------------------------------------------------
module kre_lane #(
  parameter int unsigned N_SLOTS = 6
) (
  input  logic [7:0]         old_code_i,
  input  logic [7:0]         new_code_i,
  input  logic [7:0]         prev_keys_i [N_SLOTS],
  input  logic [7:0]         new_keys_i  [N_SLOTS],
  input  logic               shift_i,
  input  logic [7:0]         enter_char_i,
  output kre_pkg::lane_evt_t evt_o
);
  import kre_pkg::*;

  logic old_in_new;
  logic new_in_prev;

  always_comb begin
    old_in_new  = 1'b0;
    new_in_prev = 1'b0;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (new_keys_i[i] == old_code_i) old_in_new = 1'b1;
      if (prev_keys_i[i] == new_code_i) new_in_prev = 1'b1;
    end
  end

  always_comb begin
    evt_o            = '0;
    evt_o.rel        = (old_code_i >= FirstCode) && !old_in_new;
    evt_o.prs        = (new_code_i >= FirstCode) && !new_in_prev;
    evt_o.old_code   = old_code_i;
    evt_o.new_code   = new_code_i;
    evt_o.char_valid = (new_code_i >= FirstCode) && (new_code_i <= LastCode);
    if (new_code_i == EnterCode) begin
      evt_o.char_code = enter_char_i;
    end else begin
      evt_o.char_code = kre_char(new_code_i, shift_i);
    end
  end

endmodule

// File: hdl/kre_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kre_merge
// Holds the lane results of one report and sends its events out in slot
// order, release before press, through an output register.
// ----------------------------------------------------------------------------
module kre_merge #(
  parameter int unsigned N_SLOTS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  kre_pkg::lane_evt_t lane_i [N_SLOTS],
  input  logic [7:0]         mod_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kre_pkg::evt_t      evt_o
);
  import kre_pkg::*;

  localparam int unsigned NEvt = 2 * N_SLOTS;

  logic [NEvt-1:0] pend_q, pend_d;
  logic [NEvt-1:0] new_mask;
  logic [NEvt-1:0] sel;
  logic [NEvt-1:0] pend_rest;
  lane_evt_t       lane_q [N_SLOTS];
  logic [7:0]      mod_q;
  logic            load_out;
  logic            out_valid_q, out_valid_d;
  evt_t            out_q, out_d;

  always_comb begin
    for (int i = 0; i < N_SLOTS; i++) begin
      new_mask[2*i]   = lane_i[i].rel;
      new_mask[2*i+1] = lane_i[i].prs;
    end
  end

  // lowest pending event first
  assign sel       = pend_q & (~pend_q + NEvt'(1));
  assign pend_rest = pend_q & ~sel;
  assign load_out  = (pend_q != '0) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (pend_q == '0) || (load_out && (pend_rest == '0));

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      pend_d = new_mask;
    end else if (load_out) begin
      pend_d = pend_rest;
    end
  end

  always_comb begin
    out_d = '0;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (sel[2*i]) begin
        out_d.usage_code = lane_q[i].old_code;
      end
      if (sel[2*i+1]) begin
        out_d.usage_code = lane_q[i].new_code;
        out_d.pressed    = 1'b1;
        out_d.modifier   = mod_q;
        out_d.char_valid = lane_q[i].char_valid;
        out_d.char_code  = lane_q[i].char_valid ? lane_q[i].char_code : 8'h00;
      end
    end
    out_d.last_event = (pend_rest == '0);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lane_q <= lane_i;
      mod_q  <= mod_i;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign evt_o       = out_q;

`include "keyboard_report_key_events_assert.svh"

  `KRE_ASSERT_IMPL(a_ready_when_drained, pend_q == '0, in_ready_o, "ready low with nothing pending")
  `KRE_ASSERT_IMPL(a_ready_drains, in_ready_o && (pend_q != '0), load_out && (pend_rest == '0), "ready high while events would remain")
  `KRE_ASSERT_NEXT(a_more_after_not_last, out_valid_q && out_ready_i && !out_q.last_event, out_valid_q, "report ended without a last event")

endmodule

// File: hdl/keyboard_report_key_events.sv
// Path: accepted findings wait in the merge's pending register, then enter the output register.
// Throughput: one event per cycle while out_ready_i is high; a report yields at most 12
//   events, one with none leaves the event queue empty and a short one never enters it.
// The next report is taken in the cycle the previous one's last event enters the output register.
// Reset: previous keys cleared to zero, enter_char back to 13, no event pending.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_key_events
// Boot keyboard report decoder: compares each report with the previous one
// and emits release and press events, with a character for presses of codes 4..56.
// ----------------------------------------------------------------------------
module keyboard_report_key_events #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: enter character
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // report items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [6:0] report_length_i,
  input  logic [7:0] modifier_bits_i,
  input  logic [7:0] key_slot_0_i,
  input  logic [7:0] key_slot_1_i,
  input  logic [7:0] key_slot_2_i,
  input  logic [7:0] key_slot_3_i,
  input  logic [7:0] key_slot_4_i,
  input  logic [7:0] key_slot_5_i,
  // event items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] usage_code_o,
  output logic       pressed_o,
  output logic [7:0] event_modifier_o,
  output logic       char_valid_o,
  output logic [7:0] char_code_o,
  output logic       last_event_o
);
  import kre_pkg::*;

  localparam int unsigned MaxSlots = 6;

  logic [7:0] enter_char_q;
  logic [7:0] prev_q   [KEY_SLOTS];
  logic [7:0] slots    [MaxSlots];
  logic [7:0] new_keys [KEY_SLOTS];
  logic       shift;
  logic       accept_full;
  lane_evt_t  lane_evt [KEY_SLOTS];
  evt_t       evt;

  // register write is always taken; writes must arrive only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_char_q <= EnterRst;
    end else if (cfg_valid_i) begin
      enter_char_q <= cfg_data_i;
    end
  end

  assign slots[0] = key_slot_0_i;
  assign slots[1] = key_slot_1_i;
  assign slots[2] = key_slot_2_i;
  assign slots[3] = key_slot_3_i;
  assign slots[4] = key_slot_4_i;
  assign slots[5] = key_slot_5_i;

  // slots beyond KEY_SLOTS are neither examined nor stored
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      new_keys[i] = slots[i];
    end
  end

  assign shift = modifier_bits_i[LShiftBit] | modifier_bits_i[RShiftBit];

  // a short report is taken and dropped: no events, previous keys kept
  assign accept_full = in_valid_i && in_ready_o && (report_length_i >= MinReport);

  // previous keys move on at acceptance; the lanes already compared
  // against the old ones in this cycle and their findings are held in the merge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_SLOTS; i++) prev_q[i] <= '0;
    end else if (accept_full) begin
      prev_q <= new_keys;
    end
  end

  // one lane per slot, all working on the same report
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    kre_lane #(
      .N_SLOTS (KEY_SLOTS)
    ) u_lane (
      .old_code_i   (prev_q[g]),
      .new_code_i   (new_keys[g]),
      .prev_keys_i  (prev_q),
      .new_keys_i   (new_keys),
      .shift_i      (shift),
      .enter_char_i (enter_char_q),
      .evt_o        (lane_evt[g])
    );
  end

  // serialises the lane findings in slot order
  kre_merge #(
    .N_SLOTS (KEY_SLOTS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept_full),
    .lane_i      (lane_evt),
    .mod_i       (modifier_bits_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .evt_o       (evt)
  );

  assign usage_code_o     = evt.usage_code;
  assign pressed_o        = evt.pressed;
  assign event_modifier_o = evt.modifier;
  assign char_valid_o     = evt.char_valid;
  assign char_code_o      = evt.char_code;
  assign last_event_o     = evt.last_event;

endmodule
